### hdl/opbb_pkg.sv
// Shared types, register codes and constants for the opaque pixel bounding box.
package opbb_pkg;

    localparam int MAX_DIM_DEFAULT = 2048;
    localparam int WORK_DEPTH      = 4;
    localparam int RESULT_DEPTH    = 2;

    localparam int COORD_W    = 11;
    localparam int EDGE_W     = 12;
    localparam int WORD_W     = 16;
    localparam int WIN_W      = 14;
    localparam int DIM_W      = 12;
    localparam int FMT_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_LEFT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_TOP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_RIGHT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_BOTTOM   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 3'd6;

    // Pixel format codes; the last two never see an opaque pixel
    localparam logic [FMT_W-1:0] FMT_ARGB1555 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_ARGB4444 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_OTHER    = 2'd2;
    localparam logic [FMT_W-1:0] FMT_SPARE    = 2'd3;

    // Alpha masks
    localparam logic [WORD_W-1:0] ALPHA_MASK_1555 = 16'h8000;
    localparam logic [WORD_W-1:0] ALPHA_MASK_4444 = 16'hF000;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [WORD_W-1:0]  pixel_word;
        logic               last_pixel;
    } pixel_item_t;

    typedef struct packed {
        logic [EDGE_W-1:0] box_left;
        logic [EDGE_W-1:0] box_top;
        logic [EDGE_W-1:0] box_right;
        logic [EDGE_W-1:0] box_bottom;
        logic              found;
    } box_item_t;

    // Classified pixel handed from front to back; the none_* edges are the
    // clipped window edges, crossed over, reported when no opaque pixel was seen.
    typedef struct packed {
        logic               hit;
        logic               last;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [EDGE_W-1:0]  none_left;
        logic [EDGE_W-1:0]  none_top;
        logic [EDGE_W-1:0]  none_right;
        logic [EDGE_W-1:0]  none_bottom;
    } work_t;

endpackage

### hdl/opbb_queue.sv
// Small first-in first-out queue built from registers.
module opbb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/opbb_front.sv
// Front end: configuration registers, window clipping and pixel classification.
module opbb_front #(
    parameter int MAX_DIM = opbb_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [opbb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [opbb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  opbb_pkg::pixel_item_t                pixel,
    output opbb_pkg::work_t                      work
);
    import opbb_pkg::*;

    localparam logic signed [WIN_W:0] DIM_CAP = (WIN_W + 1)'(MAX_DIM);

    logic signed [WIN_W-1:0] win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;
    logic [DIM_W-1:0]        image_width_reg, image_height_reg;
    logic [FMT_W-1:0]        pixel_format_reg;

    logic signed [WIN_W:0] left_s, top_s, right_s, bottom_s;
    logic signed [WIN_W:0] wmax, hmax, clip_l, clip_t, clip_r, clip_b;
    logic signed [WIN_W:0] x_s, y_s;
    logic                  in_window, opaque;

    function automatic logic [EDGE_W-1:0] clip_edge(input logic signed [WIN_W:0] v);
        logic signed [WIN_W:0] c;
        c = (v < 0) ? '0 : ((v > DIM_CAP) ? DIM_CAP : v);
        return c[EDGE_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg     <= '0;
            win_top_reg      <= '0;
            win_right_reg    <= '0;
            win_bottom_reg   <= '0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            pixel_format_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIN_LEFT:     win_left_reg     <= cfg_data[WIN_W-1:0];
                REG_WIN_TOP:      win_top_reg      <= cfg_data[WIN_W-1:0];
                REG_WIN_RIGHT:    win_right_reg    <= cfg_data[WIN_W-1:0];
                REG_WIN_BOTTOM:   win_bottom_reg   <= cfg_data[WIN_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[FMT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        left_s   = (WIN_W + 1)'(win_left_reg);
        top_s    = (WIN_W + 1)'(win_top_reg);
        right_s  = (WIN_W + 1)'(win_right_reg);
        bottom_s = (WIN_W + 1)'(win_bottom_reg);
        wmax     = signed'({3'b000, image_width_reg});
        hmax     = signed'({3'b000, image_height_reg});
        if (wmax > DIM_CAP)
        begin
            wmax = DIM_CAP;
        end
        if (hmax > DIM_CAP)
        begin
            hmax = DIM_CAP;
        end
        clip_l = left_s[WIN_W] ? '0 : left_s;
        clip_t = top_s[WIN_W] ? '0 : top_s;
        clip_r = (right_s > wmax) ? wmax : right_s;
        clip_b = (bottom_s > hmax) ? hmax : bottom_s;

        x_s = signed'({4'b0000, pixel.pixel_x});
        y_s = signed'({4'b0000, pixel.pixel_y});
        in_window = (x_s >= clip_l) && (x_s < clip_r) && (y_s >= clip_t) && (y_s < clip_b);

        unique case (pixel_format_reg)
            FMT_ARGB1555: opaque = (pixel.pixel_word & ALPHA_MASK_1555) != '0;
            FMT_ARGB4444: opaque = (pixel.pixel_word & ALPHA_MASK_4444) != '0;
            default:      opaque = 1'b0;
        endcase

        work.hit         = in_window && opaque;
        work.last        = pixel.last_pixel;
        work.x           = pixel.pixel_x;
        work.y           = pixel.pixel_y;
        work.none_left   = clip_edge(clip_r);
        work.none_top    = clip_edge(clip_b);
        work.none_right  = clip_edge(clip_l);
        work.none_bottom = clip_edge(clip_t);
    end

endmodule

### hdl/opbb_back.sv
// Back end: running min/max box and result formation on the last pixel.
module opbb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  opbb_pkg::work_t       work,
    input  logic                  work_empty,
    output logic                  work_pop,
    output logic                  result_push,
    output opbb_pkg::box_item_t   result,
    input  logic                  result_full
);
    import opbb_pkg::*;

    logic               any_reg, any_next;
    logic [COORD_W-1:0] min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic [COORD_W-1:0] min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic               grow_any;
    logic [COORD_W-1:0] grow_min_x, grow_max_x, grow_min_y, grow_max_y;

    // Hold a last pixel until the result queue has room
    assign work_pop    = !work_empty && (!work.last || !result_full);
    assign result_push = work_pop && work.last;

    always_comb
    begin
        grow_any   = any_reg;
        grow_min_x = min_x_reg;
        grow_max_x = max_x_reg;
        grow_min_y = min_y_reg;
        grow_max_y = max_y_reg;
        if (work.hit)
        begin
            grow_any = 1'b1;
            if (!any_reg || work.x < min_x_reg) grow_min_x = work.x;
            if (!any_reg || work.x > max_x_reg) grow_max_x = work.x;
            if (!any_reg || work.y < min_y_reg) grow_min_y = work.y;
            if (!any_reg || work.y > max_y_reg) grow_max_y = work.y;
        end

        result.found = grow_any;
        if (grow_any)
        begin
            result.box_left   = {1'b0, grow_min_x};
            result.box_top    = {1'b0, grow_min_y};
            result.box_right  = {1'b0, grow_max_x};
            result.box_bottom = {1'b0, grow_max_y};
        end
        else
        begin
            result.box_left   = work.none_left;
            result.box_top    = work.none_top;
            result.box_right  = work.none_right;
            result.box_bottom = work.none_bottom;
        end

        any_next   = any_reg;
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        if (work_pop)
        begin
            // Drop the box after the last pixel; otherwise advance it
            any_next   = work.last ? 1'b0 : grow_any;
            min_x_next = grow_min_x;
            max_x_next = grow_max_x;
            min_y_next = grow_min_y;
            max_y_next = grow_max_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_x_reg <= min_x_next;
        max_x_reg <= max_x_next;
        min_y_reg <= min_y_next;
        max_y_reg <= max_y_next;
    end

endmodule

### hdl/opaque_pixel_bounding_box.sv
// Top level of the opaque pixel bounding box finder.
//
//  channel   direction  handshake                 payload
//  pixel     in         push / full               pixel_item_t
//  box       out        empty / pop               box_item_t
//  config    in         cfg_write (no wait)       cfg_index, cfg_data
//
// Sustains one pixel item per cycle while the work queue is not full; the
// running min/max compare in the back end is the loop that sets this figure.
// A result item passes through the work queue and then the result queue before it appears on box.
// Reset clears the configuration registers to zero, empties both queues and
// drops any partial box; no clearing pass is needed.
// A full result queue stalls only the back end at a last pixel; the front
// keeps accepting until the work queue fills.
module opaque_pixel_bounding_box #(
    parameter int MAX_DIM = opbb_pkg::MAX_DIM_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  opbb_pkg::pixel_item_t             pixel,
    output logic                              empty,
    input  logic                              pop,
    output opbb_pkg::box_item_t               box,
    input  logic                              cfg_write,
    input  logic [opbb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [opbb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import opbb_pkg::*;

    work_t     front_work, back_work;
    logic      work_empty, work_pop;
    logic      result_push, result_full;
    box_item_t result;

    // Classify each pixel against the clipped window and the alpha format
    opbb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .work      (front_work)
    );

    // Decouple classification from accumulation
    opbb_queue #(
        .WIDTH ($bits(work_t)),
        .DEPTH (WORK_DEPTH)
    ) u_work_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_work),
        .full      (full),
        .pop       (work_pop),
        .pop_data  (back_work),
        .empty     (work_empty)
    );

    // Grow the box and form the result on the last pixel
    opbb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .work        (back_work),
        .work_empty  (work_empty),
        .work_pop    (work_pop),
        .result_push (result_push),
        .result      (result),
        .result_full (result_full)
    );

    // Hold finished results until the consumer pops them
    opbb_queue #(
        .WIDTH ($bits(box_item_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_push),
        .push_data (result),
        .full      (result_full),
        .pop       (pop),
        .pop_data  (box),
        .empty     (empty)
    );

endmodule

### hdl/opbb_checker.sv
// Port-level checks for the opaque pixel bounding box, bound to the top level.
module opbb_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              full,
    input  logic                              empty,
    input  logic                              pop,
    input  opbb_pkg::box_item_t               box
);
    import opbb_pkg::*;

    // Reset leaves both sides idle: no result item and room for input
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("block not idle after reset");

    // A found box is never inverted
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && box.found) |->
        (box.box_left <= box.box_right) && (box.box_top <= box.box_bottom))
        else $error("found box is inverted");

    // A found box lies inside the pixel coordinate range
    a_box_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && box.found) |->
        (box.box_left[EDGE_W-1] == 1'b0) && (box.box_right[EDGE_W-1] == 1'b0) &&
        (box.box_top[EDGE_W-1] == 1'b0) && (box.box_bottom[EDGE_W-1] == 1'b0))
        else $error("found box outside coordinate range");

    // A waiting result item holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(box)))
        else $error("waiting result changed");

endmodule

bind opaque_pixel_bounding_box opbb_checker u_opbb_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .box   (box)
);

### dv/opbb_box_checker.sv
// Box checker: predicts the bounding box of each scan and compares it with the block's output.
`timescale 1ns / 1ps

module opbb_box_checker #(
    parameter int MAX_DIM = opbb_pkg::MAX_DIM_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  opbb_pkg::pixel_item_t             pixel,
    input  logic                              empty,
    input  logic                              pop,
    input  opbb_pkg::box_item_t               box,
    input  logic                              cfg_write,
    input  logic [opbb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [opbb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                boxes_pending,
    output int                                boxes_seen,
    output int                                boxes_found,
    output int                                fault_count
);
    import opbb_pkg::*;

    // Mirror of the configuration registers
    logic signed [WIN_W-1:0] win_left_q   = '0;
    logic signed [WIN_W-1:0] win_top_q    = '0;
    logic signed [WIN_W-1:0] win_right_q  = '0;
    logic signed [WIN_W-1:0] win_bottom_q = '0;
    logic [DIM_W-1:0]        width_q      = '0;
    logic [DIM_W-1:0]        height_q     = '0;
    logic [FMT_W-1:0]        format_q     = '0;

    // Running box of the current scan
    logic [EDGE_W-1:0] min_col    = '0;
    logic [EDGE_W-1:0] max_col    = '0;
    logic [EDGE_W-1:0] min_row    = '0;
    logic [EDGE_W-1:0] max_row    = '0;
    logic              any_opaque = 1'b0;

    box_item_t box_expected_q[$];
    int        seen_n  = 0;
    int        found_n = 0;
    int        faults  = 0;

    function automatic logic [EDGE_W-1:0] edge_clip(input int v);
        if (v < 0)
            return '0;
        if (v > MAX_DIM)
            return EDGE_W'(MAX_DIM);
        return EDGE_W'(v);
    endfunction

    function automatic bit is_solid(input logic [WORD_W-1:0] w);
        case (format_q)
            FMT_ARGB1555: return (w & ALPHA_MASK_1555) != '0;
            FMT_ARGB4444: return (w & ALPHA_MASK_4444) != '0;
            default:      return 1'b0;
        endcase
    endfunction

    task automatic note_fault(input string what);
        faults++;
        if (faults <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    // Widen the running box with one pixel; close the scan on the last pixel.
    task automatic take_pixel(input pixel_item_t p);
        int        cl;
        int        ct;
        int        cr;
        int        cb;
        int        wmax;
        int        hmax;
        int        px;
        int        py;
        box_item_t want;
        cl   = (win_left_q < 0) ? 0 : int'(win_left_q);
        ct   = (win_top_q < 0) ? 0 : int'(win_top_q);
        wmax = (int'(width_q) > MAX_DIM) ? MAX_DIM : int'(width_q);
        hmax = (int'(height_q) > MAX_DIM) ? MAX_DIM : int'(height_q);
        cr   = (int'(win_right_q) > wmax) ? wmax : int'(win_right_q);
        cb   = (int'(win_bottom_q) > hmax) ? hmax : int'(win_bottom_q);
        px   = int'(p.pixel_x);
        py   = int'(p.pixel_y);

        if (px >= cl && px < cr && py >= ct && py < cb && is_solid(p.pixel_word)) begin
            if (!any_opaque) begin
                min_col    = EDGE_W'(px);
                max_col    = EDGE_W'(px);
                min_row    = EDGE_W'(py);
                max_row    = EDGE_W'(py);
                any_opaque = 1'b1;
            end
            else begin
                if (EDGE_W'(px) < min_col) min_col = EDGE_W'(px);
                if (EDGE_W'(px) > max_col) max_col = EDGE_W'(px);
                if (EDGE_W'(py) < min_row) min_row = EDGE_W'(py);
                if (EDGE_W'(py) > max_row) max_row = EDGE_W'(py);
            end
        end

        if (p.last_pixel) begin
            if (any_opaque) begin
                want.box_left   = min_col;
                want.box_top    = min_row;
                want.box_right  = max_col;
                want.box_bottom = max_row;
                want.found      = 1'b1;
                found_n++;
            end
            else begin
                // Nothing opaque: report the clipped window edges crossed over
                want.box_left   = edge_clip(cr);
                want.box_top    = edge_clip(cb);
                want.box_right  = edge_clip(cl);
                want.box_bottom = edge_clip(ct);
                want.found      = 1'b0;
            end
            box_expected_q.push_back(want);
            {min_col, max_col, min_row, max_row, any_opaque} = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        box_item_t want;
        if (!rst_n) begin
            win_left_q   = '0;
            win_top_q    = '0;
            win_right_q  = '0;
            win_bottom_q = '0;
            width_q      = '0;
            height_q     = '0;
            format_q     = '0;
            {min_col, max_col, min_row, max_row, any_opaque} = '0;
            box_expected_q.delete();
        end
        else begin
            // Check the outgoing box before the incoming pixel can add a new one
            if (pop && !empty) begin
                seen_n++;
                if (box_expected_q.size() == 0) begin
                    note_fault($sformatf("box %0d arrived with none expected: l=%0d t=%0d r=%0d b=%0d found=%0b",
                        seen_n, box.box_left, box.box_top, box.box_right, box.box_bottom,
                        box.found));
                end
                else begin
                    want = box_expected_q.pop_front();
                    if (box.box_left !== want.box_left || box.box_top !== want.box_top ||
                        box.box_right !== want.box_right ||
                        box.box_bottom !== want.box_bottom || box.found !== want.found) begin
                        note_fault($sformatf({"box %0d differs: expected l=%0d t=%0d r=%0d b=%0d ",
                            "found=%0b, got l=%0d t=%0d r=%0d b=%0d found=%0b"},
                            seen_n, want.box_left, want.box_top, want.box_right,
                            want.box_bottom, want.found, box.box_left, box.box_top,
                            box.box_right, box.box_bottom, box.found));
                    end
                end
            end

            // A pixel taken at this edge still sees the registers as they were
            if (push && !full)
                take_pixel(pixel);

            if (cfg_write) begin
                case (cfg_index)
                    REG_WIN_LEFT:     win_left_q   = cfg_data[WIN_W-1:0];
                    REG_WIN_TOP:      win_top_q    = cfg_data[WIN_W-1:0];
                    REG_WIN_RIGHT:    win_right_q  = cfg_data[WIN_W-1:0];
                    REG_WIN_BOTTOM:   win_bottom_q = cfg_data[WIN_W-1:0];
                    REG_IMAGE_WIDTH:  width_q      = cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: height_q     = cfg_data[DIM_W-1:0];
                    REG_PIXEL_FORMAT: format_q     = cfg_data[FMT_W-1:0];
                    default: ;
                endcase
            end
        end

        boxes_pending <= box_expected_q.size();
        boxes_seen    <= seen_n;
        boxes_found   <= found_n;
        fault_count   <= faults;
    end

endmodule

### dv/tb_opaque_pixel_bounding_box.sv
// Testbench top for the opaque pixel bounding box: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_opaque_pixel_bounding_box;
    import opbb_pkg::*;

    localparam int DIM_LIMIT       = MAX_DIM_DEFAULT;
    localparam int SETTLE_CYCLES   = 12;   // margin after the last expected box
    localparam int HOLD_CYCLES     = 300;  // long receiver hold-off to back up both queues
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 50;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    pixel_item_t pixel     = '0;
    logic        empty;
    logic        pop       = 1'b0;
    box_item_t   box;
    logic        cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int boxes_pending;
    int boxes_seen;
    int boxes_found;
    int fault_count;

    // Sender bookkeeping
    int burst_left      = 0;
    int pixels_sent     = 0;
    int settings_loaded = 0;

    opaque_pixel_bounding_box #(
        .MAX_DIM   (DIM_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .box       (box),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    opbb_box_checker #(
        .MAX_DIM       (DIM_LIMIT)
    ) box_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .pixel         (pixel),
        .empty         (empty),
        .pop           (pop),
        .box           (box),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .boxes_pending (boxes_pending),
        .boxes_seen    (boxes_seen),
        .boxes_found   (boxes_found),
        .fault_count   (fault_count)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Uniform value over the full signed range of a 14-bit window register
    function automatic int rand_edge14();
        int v;
        v = $urandom_range(0, 16383);
        return (v >= 8192) ? v - 16384 : v;
    endfunction

    // Write all seven registers back to back; only call while the block is idle.
    task automatic load_window(input int l, input int t, input int r, input int b,
                               input int w, input int h, input int fmt);
        cfg_write <= 1'b1;
        cfg_index <= REG_WIN_LEFT;     cfg_data <= CFG_DATA_W'(l);   @(posedge clk);
        cfg_index <= REG_WIN_TOP;      cfg_data <= CFG_DATA_W'(t);   @(posedge clk);
        cfg_index <= REG_WIN_RIGHT;    cfg_data <= CFG_DATA_W'(r);   @(posedge clk);
        cfg_index <= REG_WIN_BOTTOM;   cfg_data <= CFG_DATA_W'(b);   @(posedge clk);
        cfg_index <= REG_IMAGE_WIDTH;  cfg_data <= CFG_DATA_W'(w);   @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT; cfg_data <= CFG_DATA_W'(h);   @(posedge clk);
        cfg_index <= REG_PIXEL_FORMAT; cfg_data <= CFG_DATA_W'(fmt); @(posedge clk);
        cfg_write <= 1'b0;
        settings_loaded++;
    endtask

    // Offer one pixel item and hold it until the block takes it. Items go out in
    // bursts; between bursts drop push for a random gap, or none at all.
    task automatic send_pixel(input int x, input int y, input int word, input bit last);
        pixel_item_t item;
        int          gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item.pixel_x    = COORD_W'(x);
        item.pixel_y    = COORD_W'(y);
        item.pixel_word = WORD_W'(word);
        item.last_pixel = last;
        pixel <= item;
        push  <= 1'b1;
        do @(posedge clk); while (full);
        pixels_sent++;
    endtask

    // Stop offering, wait for every expected box, then let the pipeline go quiet.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (boxes_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: pop on a rotating pattern that is redrawn from random choices, sometimes
    // all ones so that long stretches run with no stall. A few times, once enough
    // boxes have come out, hold pop low for a long stretch so both queues fill up.
    initial
    begin : receiver
        logic [15:0] pattern;
        int          tick;
        int          next_hold_at;
        int          holds;
        pattern      = '1;
        tick         = 0;
        next_hold_at = 25;
        holds        = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (holds < 3 && boxes_seen >= next_hold_at) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds++;
                next_hold_at += 25;
            end
            if (tick % 48 == 0) begin
                case ($urandom_range(0, 3))
                    0:       pattern = '1;
                    1:       pattern = 16'($urandom & $urandom);
                    default: pattern = 16'($urandom);
                endcase
            end
            pop     <= pattern[0];
            pattern  = {pattern[0], pattern[15:1]};
            tick++;
        end
    end

    initial
    begin : stimulus
        int phase;
        int l;
        int t;
        int r;
        int b;
        int w;
        int h;
        int fmt;
        int lo_x;
        int hi_x;
        int lo_y;
        int hi_y;
        int x;
        int y;
        int word;
        int sel;
        int scan_len;
        int k;
        int raw;
        bit roomy;
        bit aim_in;
        bit last;

        x = 0;
        y = 0;

        // Hold reset low, then release it on a clock edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------

        // Window far beyond the image on every side, image larger than the
        // dimension limit (saturates), 1555 format.
        load_window(-2048, -2048, 4096, 4096, 4095, 4095, FMT_ARGB1555);
        send_pixel(0, 0, 16'h8000, 1'b0);        // opaque at the origin
        send_pixel(2047, 2047, 16'h8000, 1'b0);  // opaque at the far corner
        send_pixel(5, 7, 16'h7FFF, 1'b1);        // transparent last pixel closes the box
        send_pixel(100, 200, 16'hFFFF, 1'b1);    // one-pixel scan
        send_pixel(3, 3, 16'h0000, 1'b1);        // nothing opaque: edges crossed over
        settle();

        // Small window in 4444: probe each inclusive and exclusive edge
        load_window(10, 20, 30, 40, 2048, 2048, FMT_ARGB4444);
        send_pixel(10, 20, 16'h1000, 1'b0);      // top-left, smallest nonzero alpha
        send_pixel(29, 39, 16'hF000, 1'b0);      // bottom-right, inclusive
        send_pixel(30, 25, 16'hFFFF, 1'b0);      // right edge is exclusive
        send_pixel(15, 40, 16'hFFFF, 1'b0);      // bottom edge is exclusive
        send_pixel(9, 25, 16'hFFFF, 1'b0);       // one left of the window
        send_pixel(15, 19, 16'hFFFF, 1'b0);      // one above the window
        send_pixel(20, 30, 16'h0FFF, 1'b1);      // zero alpha nibble is transparent
        settle();

        // The two remaining format codes never see an opaque pixel
        load_window(10, 20, 30, 40, 2048, 2048, FMT_OTHER);
        send_pixel(15, 25, 16'hFFFF, 1'b1);
        settle();
        load_window(10, 20, 30, 40, 2048, 2048, FMT_SPARE);
        send_pixel(15, 25, 16'hFFFF, 1'b1);
        settle();

        // Inverted window: left beyond right
        load_window(100, 0, 50, 4096, 2048, 2048, FMT_ARGB1555);
        send_pixel(75, 10, 16'h8000, 1'b1);
        settle();

        // Edges far out of range: reported edges saturate at zero and the limit
        load_window(4096, 4096, -2048, -2048, 2048, 2048, FMT_ARGB1555);
        send_pixel(0, 0, 16'h8000, 1'b1);
        settle();

        // Zero-sized image with a huge window
        load_window(-2048, -2048, 4096, 4096, 0, 0, FMT_ARGB1555);
        send_pixel(0, 0, 16'hFFFF, 1'b1);
        settle();

        // ---------------- random part ----------------
        // Each phase loads a fresh window, then sends scans of random length, each
        // closed by a last pixel, until the phase's share of items is out. Most
        // pixels aim inside the clipped window, the rest are noise anywhere in the
        // coordinate space.
        for (phase = 0; phase < PHASES; phase++) begin
            fmt = ($urandom_range(0, 5) == 0) ? $urandom_range(FMT_OTHER, FMT_SPARE)
                                              : $urandom_range(FMT_ARGB1555, FMT_ARGB4444);
            case (phase % 4)
                0: begin
                    // Window wholly inside the image
                    w = $urandom_range(1, 2048);
                    h = $urandom_range(1, 2048);
                    l = $urandom_range(0, w - 1);
                    r = $urandom_range(l + 1, w);
                    t = $urandom_range(0, h - 1);
                    b = $urandom_range(t + 1, h);
                end
                1: begin
                    // Narrow window, may hang off the top or left edge
                    w = $urandom_range(64, 2048);
                    h = $urandom_range(64, 2048);
                    l = int'($urandom_range(0, w)) - 16;
                    r = l + int'($urandom_range(1, 40));
                    t = int'($urandom_range(0, h)) - 16;
                    b = t + int'($urandom_range(1, 40));
                end
                2: begin
                    // Window spills past the image; image may exceed the limit
                    w = $urandom_range(1, 4095);
                    h = $urandom_range(1, 4095);
                    l = -int'($urandom_range(0, 2048));
                    r = $urandom_range(0, 4096);
                    t = -int'($urandom_range(0, 2048));
                    b = $urandom_range(0, 4096);
                end
                default: begin
                    // Anything the register widths allow
                    l   = rand_edge14();
                    t   = rand_edge14();
                    r   = rand_edge14();
                    b   = rand_edge14();
                    w   = $urandom_range(0, 4095);
                    h   = $urandom_range(0, 4095);
                    fmt = $urandom_range(FMT_ARGB1555, FMT_SPARE);
                end
            endcase
            load_window(l, t, r, b, w, h, fmt);

            // Clip the window the way the block does to aim pixels inside it
            lo_x = (l < 0) ? 0 : l;
            lo_y = (t < 0) ? 0 : t;
            hi_x = (r > w) ? w : r;
            hi_y = (b > h) ? h : b;
            if (hi_x > DIM_LIMIT) hi_x = DIM_LIMIT;
            if (hi_y > DIM_LIMIT) hi_y = DIM_LIMIT;
            hi_x  = hi_x - 1;
            hi_y  = hi_y - 1;
            roomy = lo_x <= hi_x && lo_y <= hi_y && lo_x <= 2047 && lo_y <= 2047;

            raw = 0;
            while (raw < ITEMS_PER_PHASE) begin
                scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
                // Shorten the final scan so the phase sends its exact share
                if (scan_len > ITEMS_PER_PHASE - raw)
                    scan_len = ITEMS_PER_PHASE - raw;
                for (k = 0; k < scan_len; k++) begin
                    last   = (k == scan_len - 1);
                    aim_in = roomy && $urandom_range(0, 4) != 0;
                    sel    = $urandom_range(0, 9);
                    if (k != 0 && sel == 9) begin
                        // repeat the previous coordinates
                    end
                    else if (aim_in) begin
                        x = (sel == 0) ? lo_x : (sel == 1) ? hi_x : $urandom_range(lo_x, hi_x);
                        y = (sel == 2) ? lo_y : (sel == 3) ? hi_y : $urandom_range(lo_y, hi_y);
                    end
                    else begin
                        // noise, sometimes just past an edge
                        x = (sel == 0) ? hi_x + 1 : (sel == 1) ? lo_x - 1 : $urandom_range(0, 2047);
                        y = (sel == 2) ? hi_y + 1 : (sel == 3) ? lo_y - 1 : $urandom_range(0, 2047);
                    end
                    word = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'h0FFF)
                                                       : $urandom_range(0, 16'hFFFF);
                    send_pixel(x, y, word, last);
                    raw++;
                end
            end
            settle();
        end

        $display("covered %0d pixel items over %0d window settings", pixels_sent, settings_loaded);
        $display("checked %0d boxes, %0d of them with opaque pixels", boxes_seen, boxes_found);
        if (fault_count == 0 && boxes_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
hdl/opbb_pkg.sv
hdl/opbb_queue.sv
hdl/opbb_front.sv
hdl/opbb_back.sv
hdl/opaque_pixel_bounding_box.sv
hdl/opbb_checker.sv
dv/opbb_box_checker.sv
dv/tb_opaque_pixel_bounding_box.sv
